/* rtl/prr_pkg.sv */
// shared types, constants and codes of the polyphase rational resampler
package prr_pkg;

    // field widths of the stream items and registers
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int CIDX_W     = 10;
    localparam int FACT_W     = 5;
    localparam int HALF_W     = 9;
    localparam int CFG_W      = 9;
    localparam int COUNT_W    = 32;
    localparam int S_DATA_W   = 48;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    // default log2 of the largest tap count per output
    localparam int TAP_LOG_W  = 10;

    // defaults of the top level parameters
    localparam int COEF_DEPTH_DEF    = 1024;
    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int MAX_RATIO_DEF     = 16;

    // fixed behaviour
    localparam int MAX_RESULTS       = 16;
    localparam int HALF_LENGTH_RESET = 32;

    // register indexes
    localparam logic [1:0] REG_UP   = 2'd0;
    localparam logic [1:0] REG_DOWN = 2'd1;
    localparam logic [1:0] REG_HALF = 2'd2;

    // input item kinds
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_PAD    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_MUL,
        ST_DIV,
        ST_CHECK,
        ST_TAPS_A,
        ST_TAPS_B,
        ST_DRAIN,
        ST_ROUND
    } state_t;

    // controls from the sequencer to the mac pipeline
    typedef struct packed {
        logic clear;
        logic rd_valid;
    } mac_ctl_t;

endpackage

/* rtl/prr_ram.sv */
// generic simple dual-port ram with registered read
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/prr_mac.sv */
// multiply, scale by the up factor, accumulate, round and saturate
module prr_mac #(
    parameter int MAX_RATIO = prr_pkg::MAX_RATIO_DEF,
    parameter int TAP_W     = prr_pkg::TAP_LOG_W,
    localparam int RATIO_W = $clog2(MAX_RATIO + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  prr_pkg::mac_ctl_t                    ctl,
    input  logic signed [prr_pkg::SAMPLE_W-1:0]  x,
    input  logic signed [prr_pkg::COEF_W-1:0]    h,
    input  logic [RATIO_W-1:0]                   up,
    output logic                                 busy,
    output logic signed [prr_pkg::SAMPLE_W-1:0]  y,
    output logic                                 clip
);
    import prr_pkg::*;

    localparam int SC_W  = PROD_W + RATIO_W + 1;
    localparam int ACC_W = SC_W + TAP_W;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(65536);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SC_W-1:0]   sc_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     p_v_reg;
    logic                     s_v_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  q;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end else begin
            p_v_reg <= ctl.rd_valid;
            s_v_reg <= p_v_reg;
        end
    end

    // product, scaled product, accumulator
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(x) * PROD_W'(h);
        sc_reg   <= SC_W'(prod_reg) * SC_W'($signed({1'b0, up}));
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (s_v_reg) begin
            acc_reg <= acc_reg + {{(ACC_W-SC_W){sc_reg[SC_W-1]}}, sc_reg};
        end
    end

    assign busy = p_v_reg | s_v_reg;

    // round half up at bit 17, then saturate
    always_comb begin
        rnd = acc_reg + RND_HALF;
        q   = rnd >>> 17;
        if (q > SAT_HI) begin
            y    = SAT_HI[SAMPLE_W-1:0];
            clip = 1'b1;
        end else if (q < SAT_LO) begin
            y    = SAT_LO[SAMPLE_W-1:0];
            clip = 1'b1;
        end else begin
            y    = q[SAMPLE_W-1:0];
            clip = 1'b0;
        end
    end

endmodule

/* rtl/polyphase_rational_resampler.sv */
// polyphase rational resampler (max ratio 16 by default); a sample or pad item causes up to 16
// beats, each sequenced as position multiply, a bit-serial divide by up (one quotient bit per
// cycle), one tap per cycle from the coefficient and history rams, then a drain of the mac
// pipeline and a rounding state; pass-through loads the held sample into the output reg
// coefficient loads stay in idle; a new item is taken once the last beat sits in the output reg
// synchronous active-low reset: counters, config, state, handshakes clear; rams, data regs do not
module polyphase_rational_resampler #(
    parameter int COEF_DEPTH    = prr_pkg::COEF_DEPTH_DEF,
    parameter int HISTORY_DEPTH = prr_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_RATIO     = prr_pkg::MAX_RATIO_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [prr_pkg::CFG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // coef_index [9:0], coef_value [27:10], sample_value [43:28], zeros above
    input  logic [prr_pkg::S_DATA_W-1:0]  s_tdata,
    // action [1:0]
    input  logic [1:0]                    s_tuser,
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_sample [15:0]
    output logic [prr_pkg::SAMPLE_W-1:0]  m_tdata,
    // clipped [0]
    output logic                          m_tuser,
    // last_of_run
    output logic                          m_tlast
);
    import prr_pkg::*;

    localparam int RATIO_W = $clog2(MAX_RATIO + 1);
    localparam int POS_W   = COUNT_W + RATIO_W;
    localparam int SUM_W   = POS_W + 1;
    localparam int DC_W    = $clog2(POS_W);
    localparam int CA      = $clog2(COEF_DEPTH);
    localparam int SA      = $clog2(HISTORY_DEPTH);
    localparam int N_W     = $clog2(MAX_RESULTS + 1);
    localparam int MIN_DEPTH = (COEF_DEPTH < HISTORY_DEPTH) ? COEF_DEPTH : HISTORY_DEPTH;
    localparam int HL_LIM  = (MIN_DEPTH - 1) / 2;
    // signed coefficient index, holds -MAX_RATIO .. 2*HL_LIM+MAX_RATIO
    localparam int HX_W    = $clog2(2 * HL_LIM + MAX_RATIO + 1) + 1;
    localparam int TAP_CNT_W = $clog2(2 * HL_LIM + 1);
    localparam logic [SA-1:0] SLOT_LAST = SA'(HISTORY_DEPTH - 1);

    state_t st_reg, st_next;

    logic [FACT_W-1:0] up_reg, down_reg;
    logic [HALF_W-1:0] half_reg;
    logic [RATIO_W-1:0] up_c, down_c;
    logic [HX_W-1:0]    hl, two_hl;

    logic [COUNT_W-1:0] real_reg, spos_reg, ocnt_reg;
    logic [SA-1:0]      wr_slot_reg;
    logic [SAMPLE_W-1:0] samp_hold_reg;
    logic [N_W-1:0]     n_reg;

    logic [POS_W-1:0]   pos_reg, center_reg, src_left_reg;
    logic [DC_W-1:0]    div_cnt_reg;
    logic [RATIO_W-1:0] rem_reg;
    logic [SA-1:0]      cslot_reg, slot_reg;
    logic signed [HX_W-1:0] hidx_reg;
    logic               src_neg_reg;
    logic               iss_v_reg;

    logic               pend_reg, pend_clip_reg;
    logic [SAMPLE_W-1:0] pend_y_reg;

    logic               m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [SAMPLE_W-1:0] m_tdata_reg;

    action_t            act;
    logic [CIDX_W-1:0]  s_cidx;
    logic [COEF_W-1:0]  s_coef;
    logic [SAMPLE_W-1:0] s_samp;
    logic               accept, hist_we, coef_we, passthru;
    logic               out_free, cond, chk_go, out_load;
    logic               a_issue, b_issue, issue;
    logic               bit_in, ge;
    logic [RATIO_W:0]   trial;
    logic [SA:0]        st_slot;
    logic signed [HX_W-1:0] hidx0;

    logic [COEF_W-1:0]  coef_rd;
    logic [SAMPLE_W-1:0] hist_rd;
    mac_ctl_t           mac_ctl;
    logic               mac_busy;
    logic signed [SAMPLE_W-1:0] mac_y;
    logic               mac_clip;

    function automatic logic [SA-1:0] slot_inc(input logic [SA-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SA'(1);
    endfunction

    function automatic logic [SA-1:0] slot_dec(input logic [SA-1:0] s);
        return (s == '0) ? SLOT_LAST : s - SA'(1);
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= FACT_W'(1);
            down_reg <= FACT_W'(1);
            half_reg <= HALF_W'(HALF_LENGTH_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UP:   up_reg   <= cfg_wdata[FACT_W-1:0];
                REG_DOWN: down_reg <= cfg_wdata[FACT_W-1:0];
                REG_HALF: half_reg <= cfg_wdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // factors clamped to 1..MAX_RATIO, half length clamped to (smaller ram depth - 1) / 2
    always_comb begin
        if (up_reg == '0) begin
            up_c = RATIO_W'(1);
        end else if (8'(up_reg) > 8'(MAX_RATIO)) begin
            up_c = RATIO_W'(MAX_RATIO);
        end else begin
            up_c = RATIO_W'(up_reg);
        end
        if (down_reg == '0) begin
            down_c = RATIO_W'(1);
        end else if (8'(down_reg) > 8'(MAX_RATIO)) begin
            down_c = RATIO_W'(MAX_RATIO);
        end else begin
            down_c = RATIO_W'(down_reg);
        end
        if (32'(half_reg) > 32'(HL_LIM)) begin
            hl = HX_W'(HL_LIM);
        end else begin
            hl = HX_W'(half_reg);
        end
        two_hl = hl << 1;
    end

    // input decode and ram writes
    assign act      = action_t'(s_tuser);
    assign s_cidx   = s_tdata[9:0];
    assign s_coef   = s_tdata[27:10];
    assign s_samp   = s_tdata[43:28];
    assign s_tready = (st_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign hist_we  = accept && (act == ACT_SAMPLE || act == ACT_PAD);
    assign coef_we  = accept && (act == ACT_LOAD) && (32'(s_cidx) < 32'(COEF_DEPTH));
    assign passthru = (up_c == RATIO_W'(1)) && (down_c == RATIO_W'(1));

    // output readiness and the due check on the current position
    assign out_free = !m_tvalid_reg || m_tready;
    assign cond     = (center_reg < POS_W'(real_reg))
                   && (SUM_W'(center_reg) + SUM_W'(hl) < SUM_W'(spos_reg))
                   && (n_reg < N_W'(MAX_RESULTS));
    assign chk_go   = (st_reg == ST_CHECK) && (!pend_reg || out_free);
    assign out_load = ((st_reg == ST_PASS) && out_free) || (chk_go && pend_reg);
    assign hidx0    = $signed(hl) - $signed(HX_W'(rem_reg));

    // tap issue on both sides of the centre
    assign a_issue = (st_reg == ST_TAPS_A) && !hidx_reg[HX_W-1] && !src_neg_reg;
    assign b_issue = (st_reg == ST_TAPS_B) && (hidx_reg <= $signed(two_hl));
    assign issue   = a_issue || b_issue;

    // divider step
    assign bit_in  = pos_reg[div_cnt_reg];
    assign trial   = {rem_reg, bit_in};
    assign ge      = trial >= {1'b0, up_c};
    assign st_slot = {cslot_reg, ge};

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (accept && act == ACT_SAMPLE) begin
                    st_next = passthru ? ST_PASS : ST_MUL;
                end else if (accept && act == ACT_PAD && !passthru) begin
                    st_next = ST_MUL;
                end
            end
            ST_PASS:   if (out_free) st_next = ST_IDLE;
            ST_MUL:    st_next = ST_DIV;
            ST_DIV:    if (div_cnt_reg == '0) st_next = ST_CHECK;
            ST_CHECK:  if (chk_go) st_next = cond ? ST_TAPS_A : ST_IDLE;
            ST_TAPS_A: if (!a_issue) st_next = ST_TAPS_B;
            ST_TAPS_B: if (!b_issue) st_next = ST_DRAIN;
            ST_DRAIN:  if (!iss_v_reg && !mac_busy) st_next = ST_ROUND;
            ST_ROUND:  st_next = ST_MUL;
            default:   st_next = ST_IDLE;
        endcase
    end

    // stream counters and handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_reg     <= '0;
            spos_reg     <= '0;
            ocnt_reg     <= '0;
            wr_slot_reg  <= '0;
            n_reg        <= '0;
            pend_reg     <= 1'b0;
            iss_v_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            iss_v_reg <= issue;
            if (hist_we) begin
                wr_slot_reg <= slot_inc(wr_slot_reg);
                spos_reg    <= spos_reg + 1'b1;
                if (act == ACT_SAMPLE) begin
                    real_reg <= real_reg + 1'b1;
                end
            end
            if (accept) begin
                n_reg <= '0;
            end
            if (st_reg == ST_PASS && out_free) begin
                ocnt_reg <= ocnt_reg + 1'b1;
            end
            if (st_reg == ST_ROUND) begin
                ocnt_reg <= ocnt_reg + 1'b1;
                n_reg    <= n_reg + 1'b1;
                pend_reg <= 1'b1;
            end else if (out_load && st_reg == ST_CHECK) begin
                pend_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // position, divider and tap address datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            samp_hold_reg <= s_samp;
        end
        case (st_reg)
            ST_MUL: begin
                pos_reg     <= POS_W'(ocnt_reg) * POS_W'(down_c);
                div_cnt_reg <= DC_W'(POS_W - 1);
                rem_reg     <= '0;
                center_reg  <= '0;
                cslot_reg   <= '0;
            end
            ST_DIV: begin
                rem_reg     <= ge ? RATIO_W'(trial - {1'b0, up_c}) : RATIO_W'(trial);
                center_reg  <= {center_reg[POS_W-2:0], ge};
                cslot_reg   <= (st_slot >= (SA+1)'(HISTORY_DEPTH))
                             ? SA'(st_slot - (SA+1)'(HISTORY_DEPTH)) : SA'(st_slot);
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            ST_CHECK: begin
                hidx_reg     <= hidx0;
                src_left_reg <= center_reg;
                src_neg_reg  <= 1'b0;
                slot_reg     <= cslot_reg;
            end
            ST_TAPS_A: begin
                if (a_issue) begin
                    hidx_reg <= hidx_reg - $signed(HX_W'(up_c));
                    slot_reg <= slot_dec(slot_reg);
                    if (src_left_reg == '0) begin
                        src_neg_reg <= 1'b1;
                    end else begin
                        src_left_reg <= src_left_reg - 1'b1;
                    end
                end else begin
                    hidx_reg <= hidx0 + $signed(HX_W'(up_c));
                    slot_reg <= slot_inc(cslot_reg);
                end
            end
            ST_TAPS_B: begin
                if (b_issue) begin
                    hidx_reg <= hidx_reg + $signed(HX_W'(up_c));
                    slot_reg <= slot_inc(slot_reg);
                end
            end
            ST_ROUND: begin
                pend_y_reg    <= mac_y;
                pend_clip_reg <= mac_clip;
            end
            default: ;
        endcase
        // output beat register
        if (out_load) begin
            if (st_reg == ST_PASS) begin
                m_tdata_reg <= samp_hold_reg;
                m_tuser_reg <= 1'b0;
                m_tlast_reg <= 1'b1;
            end else begin
                m_tdata_reg <= pend_y_reg;
                m_tuser_reg <= pend_clip_reg;
                m_tlast_reg <= !cond;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // coefficient store
    prr_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (CA'(s_cidx)),
        .wdata (s_coef),
        .raddr (CA'($unsigned(hidx_reg))),
        .rdata (coef_rd)
    );

    // sample history
    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (wr_slot_reg),
        .wdata ((act == ACT_SAMPLE) ? s_samp : '0),
        .raddr (slot_reg),
        .rdata (hist_rd)
    );

    // mac pipeline
    assign mac_ctl.clear    = chk_go && cond;
    assign mac_ctl.rd_valid = iss_v_reg;

    prr_mac #(
        .MAX_RATIO (MAX_RATIO),
        .TAP_W     (TAP_CNT_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .x       ($signed(hist_rd)),
        .h       ($signed(coef_rd)),
        .up      (up_c),
        .busy    (mac_busy),
        .y       (mac_y),
        .clip    (mac_clip)
    );

    // a finished result never overwrites one still waiting
    a_no_pend_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_ROUND) |-> !pend_reg)
        else $error("pending result overwritten");

    // the per-item result cap holds
    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= N_W'(MAX_RESULTS))
        else $error("result cap exceeded");

    // ram reads only come from the tap passes
    a_read_in_taps: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_v_reg |-> ($past(st_reg) == ST_TAPS_A || $past(st_reg) == ST_TAPS_B))
        else $error("tap read outside tap pass");

endmodule

/* bench/tb_polyphase_rational_resampler.sv */
`timescale 1ns / 100ps
// self-checking bench for the polyphase rational resampler: queued stimulus, predictor, scoreboard
module tb_polyphase_rational_resampler;
    import prr_pkg::*;

    localparam int HIST_D        = HISTORY_DEPTH_DEF;
    localparam int HALF_MAX      = (HISTORY_DEPTH_DEF - 1) / 2;
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef enum logic [2:0] {
        OP_BEAT,
        OP_CFG,
        OP_DRAIN,
        OP_MODE,
        OP_HOLD,
        OP_END
    } op_kind_t;

    typedef struct {
        op_kind_t    kind;
        action_t     act;
        logic [9:0]  cidx;
        logic [17:0] cval;
        logic [15:0] sval;
        logic [1:0]  reg_idx;
        logic [8:0]  reg_val;
        int          tx_pct;
        int          rx_pct;
    } stim_op_t;

    typedef struct {
        logic [15:0] smp;
        logic        clip;
        logic        last;
    } out_beat_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [SAMPLE_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // predictor copy of the block state
    int          coef_mem [COEF_DEPTH_DEF];
    int          hist_mem [HIST_D];
    logic [31:0] real_cnt;
    logic [31:0] stream_pos;
    logic [31:0] out_cnt;
    logic [4:0]  up_reg;
    logic [4:0]  down_reg;
    logic [8:0]  half_reg;

    out_beat_t expected_beats [$];
    stim_op_t  stim_ops [$];

    logic s_fire;
    bit   stim_done;
    bit   timed_out;
    int   fail_cnt;
    int   cycle_cnt;
    int   settle_left;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   hold_req;
    bit   hold_seen;
    int   hold_left;

    polyphase_rational_resampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    function automatic int clamp_ratio(logic [4:0] f);
        if (f == 0) return 1;
        if (f > MAX_RATIO_DEF) return MAX_RATIO_DEF;
        return int'(f);
    endfunction

    // work out the output beats that one accepted input beat causes
    task automatic predict_resampled(action_t act, logic [9:0] ci, logic [17:0] cv,
                                     logic [15:0] sv);
        int up, down, hl, n, phase, hidx, k, s;
        longint unsigned pos, center;
        longint acc, src, q;
        out_beat_t b;
        up   = clamp_ratio(up_reg);
        down = clamp_ratio(down_reg);
        if (act == ACT_LOAD) begin
            coef_mem[ci] = $signed(cv);
            return;
        end
        if (act == ACT_NONE) return;
        s = (act == ACT_SAMPLE) ? $signed(sv) : 0;
        hist_mem[stream_pos % HIST_D] = s;
        stream_pos = stream_pos + 1;
        if (act == ACT_SAMPLE) real_cnt = real_cnt + 1;
        // pass-through
        if (up == 1 && down == 1) begin
            if (act == ACT_SAMPLE) begin
                b.smp  = sv;
                b.clip = 1'b0;
                b.last = 1'b1;
                expected_beats.push_back(b);
                out_cnt = out_cnt + 1;
            end
            return;
        end
        hl = (half_reg > HALF_MAX) ? HALF_MAX : int'(half_reg);
        n = 0;
        while (n < MAX_RESULTS) begin
            pos    = longint'(out_cnt) * longint'(down);
            center = pos / longint'(up);
            phase  = int'(pos % longint'(up));
            if (center >= longint'(real_cnt)) break;
            if (center + longint'(hl) >= longint'(stream_pos)) break;
            acc = 0;
            for (k = -hl; k <= hl; k++) begin
                hidx = hl + k * up - phase;
                src  = longint'(center) + k;
                if (hidx >= 0 && hidx <= 2 * hl && src >= 0)
                    acc += longint'(hist_mem[src % HIST_D]) * longint'(coef_mem[hidx]);
            end
            // scale by up, round half up, saturate
            q = (acc * up + 65536) >>> 17;
            b.clip = 1'b0;
            if (q > 32767) begin
                q = 32767;
                b.clip = 1'b1;
            end
            if (q < -32768) begin
                q = -32768;
                b.clip = 1'b1;
            end
            b.smp  = q[15:0];
            b.last = 1'b0;
            expected_beats.push_back(b);
            out_cnt = out_cnt + 1;
            n++;
        end
        if (n > 0) expected_beats[$].last = 1'b1;
    endtask

    // stimulus queue helpers
    task automatic push_beat(action_t act, logic [9:0] ci, logic [17:0] cv, logic [15:0] sv);
        stim_op_t op;
        op.kind = OP_BEAT;
        op.act  = act;
        op.cidx = ci;
        op.cval = cv;
        op.sval = sv;
        stim_ops.push_back(op);
    endtask

    task automatic push_cfg(logic [1:0] idx, logic [8:0] val);
        stim_op_t op;
        op.kind    = OP_CFG;
        op.reg_idx = idx;
        op.reg_val = val;
        stim_ops.push_back(op);
    endtask

    task automatic push_ctl(op_kind_t kind);
        stim_op_t op;
        op.kind = kind;
        stim_ops.push_back(op);
    endtask

    task automatic push_mode(int tx, int rx);
        stim_op_t op;
        op.kind   = OP_MODE;
        op.tx_pct = tx;
        op.rx_pct = rx;
        stim_ops.push_back(op);
    endtask

    function automatic logic [17:0] rand_coef();
        logic [17:0] v;
        v = 18'($urandom);
        if ($urandom_range(9) == 0) v = $urandom_range(1) ? 18'h1ffff : 18'h20000;
        return v;
    endfunction

    function automatic logic [15:0] rand_sample();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(9) == 0) v = $urandom_range(1) ? 16'h7fff : 16'h8000;
        return v;
    endfunction

    // one setting: idle, program, load taps, optional hold, random beats, then pads to flush the tail
    task automatic add_phase(int up, int down, int hl, int n_rand, bit long_hold);
        int eh, pick, i;
        push_ctl(OP_DRAIN);
        push_cfg(REG_UP, 9'(up));
        push_cfg(REG_DOWN, 9'(down));
        push_cfg(REG_HALF, 9'(hl));
        eh = (hl > HALF_MAX) ? HALF_MAX : hl;
        for (i = 0; i <= 2 * eh; i++)
            push_beat(ACT_LOAD, 10'(i), rand_coef(), 16'($urandom));
        if (long_hold) push_ctl(OP_HOLD);
        for (i = 0; i < n_rand; i++) begin
            pick = $urandom_range(99);
            if (pick < 82)
                push_beat(ACT_SAMPLE, 10'($urandom), 18'($urandom), rand_sample());
            else if (pick < 90)
                push_beat(ACT_PAD, 10'($urandom), 18'($urandom), 16'($urandom));
            else if (pick < 95)
                push_beat(ACT_NONE, 10'($urandom), 18'($urandom), 16'($urandom));
            else
                push_beat(ACT_LOAD, 10'($urandom_range(2 * eh)), rand_coef(), 16'($urandom));
        end
        for (i = 0; i <= eh; i++)
            push_beat(ACT_PAD, 10'($urandom), 18'($urandom), 16'($urandom));
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) timed_out = 1'b1;
    end

    // monitor and scoreboard, predictor fed from accepted beats
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_UP:   up_reg   = cfg_wdata[4:0];
                    REG_DOWN: down_reg = cfg_wdata[4:0];
                    REG_HALF: half_reg = cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected output beat: out_sample %0d", $signed(m_tdata));
                    fail_cnt++;
                end else begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.smp) begin
                        $error("out_sample expected %0d actual %0d",
                               $signed(want.smp), $signed(m_tdata));
                        fail_cnt++;
                    end
                    if (m_tuser !== want.clip) begin
                        $error("clipped expected %0b actual %0b", want.clip, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run expected %0b actual %0b", want.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_resampled(action_t'(s_tuser), s_tdata[9:0], s_tdata[27:10],
                                  s_tdata[43:28]);
            s_fire <= s_tvalid && s_tready;
        end
    end

    // driver: beats, register writes and pauses from the stimulus queue
    always @(negedge aclk) begin
        logic nv, nw;
        stim_op_t op;
        if (aresetn && !(s_tvalid && !s_fire)) begin
            nv = 1'b0;
            nw = 1'b0;
            if (settle_left > 0) begin
                settle_left--;
            end else if (stim_ops.size() > 0) begin
                op = stim_ops[0];
                case (op.kind)
                    OP_BEAT: begin
                        if ($urandom_range(99) >= tx_idle_pct) begin
                            nv = 1'b1;
                            s_tdata <= {4'b0, op.sval, op.cval, op.cidx};
                            s_tuser <= op.act;
                            void'(stim_ops.pop_front());
                        end
                    end
                    OP_CFG: begin
                        nw = 1'b1;
                        cfg_index <= op.reg_idx;
                        cfg_wdata <= op.reg_val;
                        void'(stim_ops.pop_front());
                    end
                    OP_DRAIN: begin
                        if (expected_beats.size() == 0) begin
                            settle_left = SETTLE_CYCLES;
                            void'(stim_ops.pop_front());
                        end
                    end
                    OP_MODE: begin
                        tx_idle_pct = op.tx_pct;
                        rx_idle_pct = op.rx_pct;
                        void'(stim_ops.pop_front());
                    end
                    OP_HOLD: begin
                        hold_req = !hold_req;
                        void'(stim_ops.pop_front());
                    end
                    OP_END: begin
                        stim_done = 1'b1;
                        void'(stim_ops.pop_front());
                    end
                    default: void'(stim_ops.pop_front());
                endcase
            end
            s_tvalid  <= nv;
            cfg_wr_en <= nw;
        end
    end

    // receiver: random back-pressure, long hold on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int i;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        real_cnt   = '0;
        stream_pos = '0;
        out_cnt    = '0;
        up_reg     = 5'd1;
        down_reg   = 5'd1;
        half_reg   = 9'(HALF_LENGTH_RESET);
        for (i = 0; i < HIST_D; i++) hist_mem[i] = 0;
        for (i = 0; i < COEF_DEPTH_DEF; i++) coef_mem[i] = 0;

        // directed: reset settings give pass-through; sample extremes, pad, unused action, loads
        push_mode(26, 65);
        push_beat(ACT_SAMPLE, 10'h000, 18'h00000, 16'h7fff);
        push_beat(ACT_SAMPLE, 10'h3ff, 18'h3ffff, 16'h8000);
        push_beat(ACT_SAMPLE, 10'h000, 18'h00000, 16'h0000);
        push_beat(ACT_SAMPLE, 10'h155, 18'h15555, 16'hffff);
        push_beat(ACT_PAD,    10'h3ff, 18'h3ffff, 16'hffff);
        push_beat(ACT_NONE,   10'h3ff, 18'h3ffff, 16'hffff);
        push_beat(ACT_LOAD,   10'h3ff, 18'h20000, 16'hffff);
        push_beat(ACT_LOAD,   10'h000, 18'h1ffff, 16'h0000);
        push_beat(ACT_SAMPLE, 10'h2aa, 18'h2aaaa, 16'h0001);

        // phases ordered by rising up/down ratio so the output position never runs ahead
        add_phase(2, 31, 0, 30, 1'b0);
        add_phase(0, 2, 8, 30, 1'b0);
        add_phase(2, 3, 2, 30, 1'b0);
        push_mode(65, 26);
        add_phase(5, 7, 3, 30, 1'b1);
        add_phase(1, 1, 5, 28, 1'b0);
        add_phase(7, 5, 16, 30, 1'b0);
        push_mode(0, 0);
        add_phase(3, 2, 4, 30, 1'b0);
        add_phase(4, 1, 6, 28, 1'b1);
        add_phase(31, 0, 1, 25, 1'b0);
        push_ctl(OP_DRAIN);
        push_ctl(OP_END);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (stim_done || timed_out);
        if (!timed_out && fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
